>>> hdl/keyed_event_stack_table_macros.svh
// Assertion macros for the keyed event stack table.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef KEYED_EVENT_STACK_TABLE_MACROS_SVH
`define KEYED_EVENT_STACK_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication check
`define KEST_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check
`define KEST_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define KEST_ASSERT_NOW(name, clk, rstn, ante, cons, msg)
`define KEST_ASSERT_NEXT(name, clk, rstn, ante, cons, msg)

`endif

`endif

>>> hdl/kest_pkg.sv
// Shared types and constants for the keyed event stack table.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package kest_pkg;

  // Table geometry
  localparam int unsigned TABLE_CAPACITY = 64;
  localparam int unsigned STACK_DEPTH    = 30;
  localparam int unsigned HANDLE_WIDTH   = 16;

  // Field widths
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned STATUS_W = 3;

  // Derived widths
  localparam int unsigned SLOT_W      = $clog2(TABLE_CAPACITY);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned LOGC_W      = $clog2(TABLE_CAPACITY + 1);
  localparam int unsigned STACK_WORDS = TABLE_CAPACITY * STACK_DEPTH;
  localparam int unsigned STACK_AW    = $clog2(STACK_WORDS);

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_LOG_FULL    = 3'd1,
    ST_STACK_FULL  = 3'd2,
    ST_KEY_UNKNOWN = 3'd3,
    ST_STACK_EMPTY = 3'd4,
    ST_INDEX_RANGE = 3'd5
  } status_e;

  typedef struct packed {
    opcode_e                 opcode;
    logic [KEY_W-1:0]        key;
    logic [HANDLE_WIDTH-1:0] handle;
    logic [IDX_W-1:0]        log_index;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [HANDLE_WIDTH-1:0] result_handle;
    logic [LOGC_W-1:0]       event_count;
  } out_item_t;

  // Step commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic match;
    logic count;
    logic access;
    logic finish;
  } cmd_t;

endpackage

`default_nettype wire

>>> hdl/kest_ctrl.sv
// Sequencer for the keyed event stack table: input and output handshakes
// and the per-item step commands. Depends on kest_pkg.
`default_nettype none

module kest_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output kest_pkg::cmd_t cmd_o
);
  import kest_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_MATCH  = 5'b00010,
    S_COUNT  = 5'b00100,
    S_ACCESS = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   finish;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Load the output register once it is empty or being drained
  assign finish = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Drive step commands
  always_comb begin
    cmd_o.capture = in_valid_i && (state_q == S_IDLE);
    cmd_o.match   = (state_q == S_MATCH);
    cmd_o.count   = (state_q == S_COUNT);
    cmd_o.access  = (state_q == S_ACCESS);
    cmd_o.finish  = finish;
  end

  // Advance through the steps of one item
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_MATCH;
      end
      S_MATCH:  state_d = S_COUNT;
      S_COUNT:  state_d = S_ACCESS;
      S_ACCESS: state_d = S_DONE;
      S_DONE: begin
        if (finish) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Hold the result valid until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/kest_datapath.sv
// Datapath of the keyed event stack table: key slots, stack and log
// memories, log count and the output register. Depends on kest_pkg.
`default_nettype none

module kest_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kest_pkg::in_item_t  in_data_i,
  input  kest_pkg::cmd_t      cmd_i,
  output kest_pkg::out_item_t out_data_o
);
  import kest_pkg::*;

  typedef enum logic [1:0] {
    RES_ZERO  = 2'd0,
    RES_STACK = 2'd1,
    RES_LOG   = 2'd2
  } res_sel_e;

  // Lowest set bit of a slot vector
  function automatic logic [SLOT_W-1:0] lowest_set(input logic [TABLE_CAPACITY-1:0] v);
    logic [SLOT_W-1:0] r;
    r = '0;
    for (int i = TABLE_CAPACITY - 1; i >= 0; i--) begin
      if (v[i]) r = SLOT_W'(i);
    end
    return r;
  endfunction

  in_item_t                 item_q;

  // Key slots, one comparator each
  logic [TABLE_CAPACITY-1:0] key_valid_q;
  logic [KEY_W-1:0]          key_q [TABLE_CAPACITY];

  // Memories
  logic [CNT_W-1:0]          cnt_mem   [TABLE_CAPACITY];
  logic [HANDLE_WIDTH-1:0]   stack_mem [STACK_WORDS];
  logic [HANDLE_WIDTH-1:0]   log_mem   [TABLE_CAPACITY];

  logic [LOGC_W-1:0]         log_count_q;

  // Match step results
  logic [TABLE_CAPACITY-1:0] hit_vec;
  logic                      hit_q;
  logic                      tab_full_q;
  logic [SLOT_W-1:0]         slot_q;
  logic [HANDLE_WIDTH-1:0]   log_rd_q;

  // Count step results
  logic [CNT_W-1:0]          cnt_rd_q;
  logic [STACK_AW-1:0]       base_q;

  // Access step
  logic [CNT_W-1:0]          cnt;
  logic                      push_ok;
  logic                      pop_ok;
  logic                      read_ok;
  status_e                   status;
  status_e                   status_q;
  res_sel_e                  res_sel_q;
  logic [STACK_AW-1:0]       push_addr;
  logic [STACK_AW-1:0]       pop_addr;
  logic [HANDLE_WIDTH-1:0]   stack_rd_q;

  out_item_t                 out_q;

  assign out_data_o = out_q;

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_data_i;
  end

  // Compare the key against every slot
  always_comb begin
    for (int i = 0; i < TABLE_CAPACITY; i++) begin
      hit_vec[i] = key_valid_q[i] && (key_q[i] == item_q.key);
    end
  end

  // Register slot choice and the log entry read
  always_ff @(posedge clk_i) begin
    if (cmd_i.match) begin
      hit_q      <= |hit_vec;
      tab_full_q <= !(|hit_vec) && (&key_valid_q);
      slot_q     <= (|hit_vec) ? lowest_set(hit_vec) : lowest_set(~key_valid_q);
      log_rd_q   <= log_mem[item_q.log_index[SLOT_W-1:0]];
    end
  end

  // Fetch the stack count and the stack base address
  always_ff @(posedge clk_i) begin
    if (cmd_i.count) begin
      cnt_rd_q <= cnt_mem[slot_q];
      base_q   <= STACK_AW'(slot_q * STACK_DEPTH);
    end
  end

  // A new key starts with an empty stack
  assign cnt       = hit_q ? cnt_rd_q : '0;
  assign push_addr = base_q + STACK_AW'(cnt);
  assign pop_addr  = base_q + STACK_AW'(cnt - CNT_W'(1));

  // Decide the outcome of the item
  always_comb begin
    push_ok = 1'b0;
    pop_ok  = 1'b0;
    read_ok = 1'b0;
    status  = ST_OK;
    case (item_q.opcode)
      OP_PUSH: begin
        if (log_count_q >= LOGC_W'(TABLE_CAPACITY) || tab_full_q) begin
          status = ST_LOG_FULL;
        end else if (cnt >= CNT_W'(STACK_DEPTH)) begin
          status = ST_STACK_FULL;
        end else begin
          push_ok = 1'b1;
        end
      end
      OP_POP: begin
        if (!hit_q) begin
          status = ST_KEY_UNKNOWN;
        end else if (cnt == '0 || cnt > CNT_W'(STACK_DEPTH)) begin
          status = ST_STACK_EMPTY;
        end else begin
          pop_ok = 1'b1;
        end
      end
      OP_READ: begin
        if (LOGC_W'(item_q.log_index) >= log_count_q) begin
          status = ST_INDEX_RANGE;
        end else begin
          read_ok = 1'b1;
        end
      end
      default: status = ST_OK;
    endcase
  end

  // Update memories and latch the outcome
  always_ff @(posedge clk_i) begin
    if (cmd_i.access) begin
      status_q <= status;
      if (pop_ok) begin
        res_sel_q <= RES_STACK;
      end else if (read_ok) begin
        res_sel_q <= RES_LOG;
      end else begin
        res_sel_q <= RES_ZERO;
      end
      if (push_ok) begin
        stack_mem[push_addr]                  <= item_q.handle;
        log_mem[log_count_q[SLOT_W-1:0]]      <= item_q.handle;
        cnt_mem[slot_q]                       <= cnt + CNT_W'(1);
        key_q[slot_q]                         <= item_q.key;
      end else if (pop_ok) begin
        cnt_mem[slot_q]                       <= cnt - CNT_W'(1);
        stack_rd_q                            <= stack_mem[pop_addr];
      end
    end
  end

  // Mark new keys and count logged handles
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_valid_q <= '0;
      log_count_q <= '0;
    end else if (cmd_i.access && push_ok) begin
      key_valid_q[slot_q] <= 1'b1;
      log_count_q         <= log_count_q + LOGC_W'(1);
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.status      <= status_q;
      out_q.event_count <= log_count_q;
      case (res_sel_q)
        RES_STACK: out_q.result_handle <= stack_rd_q;
        RES_LOG:   out_q.result_handle <= log_rd_q;
        default:   out_q.result_handle <= '0;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/keyed_event_stack_table.sv
// Top level of the keyed event stack table: controller plus datapath.
// Depends on kest_pkg, kest_ctrl, kest_datapath and the assertion macros.
`default_nettype none

`include "keyed_event_stack_table_macros.svh"

// Keyed event stack table. Each push finds the key by matching it against all
// 64 key slots at once (a new key takes the lowest free slot), pushes the
// handle onto that key's stack of up to 30 entries and appends it to a
// 64-entry event log; pop returns the key's top handle and read returns a log
// entry by index. Each item gives exactly one result with a status and the
// log count. An item passes through the steps key match, stack count memory
// read, stack memory access and result load, each memory read being
// registered. No new item is taken until the last result is loaded; the
// next item is accepted in the cycle after that, also while that result
// still waits in the output register; a result that finds the output
// register full waits until it drains. No clearing pass is needed after reset.
module keyed_event_stack_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  kest_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output kest_pkg::out_item_t out_data_o
);
  import kest_pkg::*;

  cmd_t cmd;

  kest_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  kest_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .out_data_o (out_data_o)
  );

  // Checks
  `KEST_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni,
                    in_valid_i && in_ready_o, !in_ready_o,
                    "item accepted while previous still in work")
  `KEST_ASSERT_NOW(a_count_bound, clk_i, rst_ni,
                   out_valid_o, out_data_o.event_count <= LOGC_W'(TABLE_CAPACITY),
                   "event count beyond log capacity")
  `KEST_ASSERT_NOW(a_zero_on_error, clk_i, rst_ni,
                   out_valid_o && (out_data_o.status != ST_OK),
                   out_data_o.result_handle == '0,
                   "nonzero handle with error status")

endmodule

`default_nettype wire
